/* rtl/assert_macros.svh */
// assertion macros used by mpqa_core
// every macro samples on aclk and is held off while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold at every edge out of reset
`define MPQA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// same-cycle implication
`define MPQA_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define MPQA_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/mpqa_pkg.sv */
// shared types and constants for the min priority queue block
// no dependencies
package mpqa_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int OCC_W    = 5;
    localparam int STAT_W   = 2;

    localparam int IN_TDATA_W  = ((VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VAL_W + OCC_W + 7) / 8) * 8;

    typedef enum logic [STAT_W-1:0] {
        STAT_ENQUEUED = 2'd0,
        STAT_DEQUEUED = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    typedef enum logic {
        OP_ENQUEUE = 1'b0,
        OP_DEQUEUE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic signed [VAL_W-1:0]  item_value;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [VAL_W-1:0]  out_value;
        logic [OCC_W-1:0]         occupancy;
    } res_t;

endpackage

/* rtl/mpqa_core.sv */
// queue storage, sequencer and the shared compare unit
// depends on mpqa_pkg and assert_macros.svh
`include "assert_macros.svh"

module mpqa_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           req_valid,
    output logic           req_ready,
    input  mpqa_pkg::req_t req,
    output logic           res_valid,
    input  logic           res_ready,
    output mpqa_pkg::res_t res
);

    mpqa_pkg::state_t  state_reg, state_next;
    mpqa_pkg::status_t status_reg, status_next;

    logic [mpqa_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [mpqa_pkg::IDX_W-1:0]        idx_reg, idx_next;
    logic [mpqa_pkg::IDX_W-1:0]        pick_reg, pick_next;
    logic signed [mpqa_pkg::VAL_W-1:0] best_reg, best_next;
    logic signed [mpqa_pkg::VAL_W-1:0] rdata_reg;

    logic signed [mpqa_pkg::VAL_W-1:0] mem [mpqa_pkg::CAPACITY];

    logic [mpqa_pkg::IDX_W-1:0]        rd_addr;
    logic                              wr_en;
    logic [mpqa_pkg::IDX_W-1:0]        wr_addr;
    logic signed [mpqa_pkg::VAL_W-1:0] wr_data;

    logic [mpqa_pkg::CNT_W-1:0]        count_m1;
    logic [mpqa_pkg::CNT_W-1:0]        idx_ext;
    logic                              is_full;
    logic                              is_empty;
    logic                              accept;
    logic                              scan_take;
    logic                              scan_last;
    logic [mpqa_pkg::IDX_W-1:0]        final_pick;
    logic signed [mpqa_pkg::VAL_W-1:0] final_best;
    logic                              pick_is_last;
    logic                              shift_last;

    assign count_m1     = count_reg - mpqa_pkg::CNT_W'(1);
    assign idx_ext      = mpqa_pkg::CNT_W'(idx_reg);
    assign is_full      = (count_reg == mpqa_pkg::CNT_W'(mpqa_pkg::CAPACITY));
    assign is_empty     = (count_reg == '0);
    assign req_ready    = (state_reg == mpqa_pkg::S_IDLE);
    assign accept       = req_valid && req_ready;

    // the one comparator: first entry always taken, later ones only if strictly smaller
    assign scan_take    = (idx_reg == '0) || (rdata_reg < best_reg);
    assign scan_last    = (idx_ext == count_m1);
    assign final_pick   = scan_take ? idx_reg : pick_reg;
    assign final_best   = scan_take ? rdata_reg : best_reg;
    assign pick_is_last = (mpqa_pkg::CNT_W'(final_pick) == count_m1);
    assign shift_last   = ((idx_ext + mpqa_pkg::CNT_W'(1)) == count_m1);

    assign res_valid     = (state_reg == mpqa_pkg::S_RESP);
    assign res.status    = status_reg;
    assign res.out_value = best_reg;
    assign res.occupancy = mpqa_pkg::OCC_W'(count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mpqa_pkg::S_IDLE: begin
                if (accept) begin
                    if (req.opcode == mpqa_pkg::OP_ENQUEUE || is_empty) begin
                        state_next = mpqa_pkg::S_RESP;
                    end else begin
                        state_next = mpqa_pkg::S_SCAN;
                    end
                end
            end
            mpqa_pkg::S_SCAN: begin
                if (scan_last) begin
                    state_next = pick_is_last ? mpqa_pkg::S_RESP : mpqa_pkg::S_SHIFT;
                end
            end
            mpqa_pkg::S_SHIFT: begin
                if (shift_last) begin
                    state_next = mpqa_pkg::S_RESP;
                end
            end
            mpqa_pkg::S_RESP: begin
                if (res_ready) begin
                    state_next = mpqa_pkg::S_IDLE;
                end
            end
            default: state_next = mpqa_pkg::S_IDLE;
        endcase
    end

    // datapath and memory port control
    always_comb begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        pick_next   = pick_reg;
        best_next   = best_reg;
        status_next = status_reg;
        rd_addr     = '0;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rdata_reg;
        case (state_reg)
            mpqa_pkg::S_IDLE: begin
                if (accept) begin
                    best_next = '0;
                    if (req.opcode == mpqa_pkg::OP_ENQUEUE) begin
                        if (is_full) begin
                            status_next = mpqa_pkg::STAT_FULL;
                        end else begin
                            wr_en       = 1'b1;
                            wr_addr     = count_reg[mpqa_pkg::IDX_W-1:0];
                            wr_data     = req.item_value;
                            count_next  = count_reg + mpqa_pkg::CNT_W'(1);
                            status_next = mpqa_pkg::STAT_ENQUEUED;
                        end
                    end else if (is_empty) begin
                        status_next = mpqa_pkg::STAT_EMPTY;
                    end else begin
                        status_next = mpqa_pkg::STAT_DEQUEUED;
                        rd_addr     = '0;
                        idx_next    = '0;
                        pick_next   = '0;
                    end
                end
            end
            mpqa_pkg::S_SCAN: begin
                best_next = final_best;
                pick_next = final_pick;
                if (scan_last) begin
                    if (pick_is_last) begin
                        count_next = count_m1;
                    end else begin
                        // prime the shift with the entry just above the winner
                        rd_addr  = final_pick + mpqa_pkg::IDX_W'(1);
                        idx_next = final_pick;
                    end
                end else begin
                    rd_addr  = idx_reg + mpqa_pkg::IDX_W'(1);
                    idx_next = idx_reg + mpqa_pkg::IDX_W'(1);
                end
            end
            mpqa_pkg::S_SHIFT: begin
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rdata_reg;
                if (shift_last) begin
                    count_next = count_m1;
                end else begin
                    rd_addr  = idx_reg + mpqa_pkg::IDX_W'(2);
                    idx_next = idx_reg + mpqa_pkg::IDX_W'(1);
                end
            end
            mpqa_pkg::S_RESP: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mpqa_pkg::S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        pick_reg   <= pick_next;
        best_reg   <= best_next;
        status_reg <= status_next;
    end

    `MPQA_ASSERT(a_count_bound, count_reg <= mpqa_pkg::CNT_W'(mpqa_pkg::CAPACITY), "count above capacity")
    `MPQA_ASSERT_IMP(a_idx_in_range, state_reg == mpqa_pkg::S_SCAN || state_reg == mpqa_pkg::S_SHIFT, idx_ext < count_reg, "walk index beyond held entries")
    `MPQA_ASSERT_NXT(a_enq_grows, accept && req.opcode == mpqa_pkg::OP_ENQUEUE && !is_full, count_reg == $past(count_reg) + mpqa_pkg::CNT_W'(1), "enqueue did not grow count")
    `MPQA_ASSERT_IMP(a_empty_clean, res_valid && status_reg == mpqa_pkg::STAT_EMPTY, best_reg == '0 && count_reg == '0, "empty result not clean")

endmodule

/* rtl/min_priority_queue_array_top.sv */
// top level of the min priority queue: stream ports and result register
// depends on mpqa_pkg and mpqa_core
// Min priority queue over a fixed 16-entry store kept in arrival order. Every
// request gives one result. An enqueue writes the store when it is accepted and
// then passes through the response state to the result register. A dequeue
// reads the store once per cycle through its single read port, first comparing
// every held entry against the running minimum, then moving each later entry
// down one place. Dequeue on an empty queue and enqueue on a full one leave the
// store unchanged and return a status with a zero out_value.
// No new request is taken while one is in progress; a finished result may wait
// in the output register while the next request is already being worked on.
module min_priority_queue_array_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mpqa_pkg::IN_TDATA_W-1:0]      s_tdata,   // item_value
    input  logic                                 s_tuser,   // opcode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mpqa_pkg::OUT_TDATA_W-1:0]     m_tdata,   // out_value, occupancy, zero pad
    output logic [mpqa_pkg::STAT_W-1:0]          m_tuser    // status
);

    mpqa_pkg::req_t req;
    mpqa_pkg::res_t res;
    logic           res_valid;
    logic           res_ready;

    logic                                m_tvalid_reg, m_tvalid_next;
    logic [mpqa_pkg::OUT_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic [mpqa_pkg::STAT_W-1:0]         m_tuser_reg, m_tuser_next;

    assign req.opcode     = mpqa_pkg::opcode_t'(s_tuser);
    assign req.item_value = s_tdata[mpqa_pkg::VAL_W-1:0];

    mpqa_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // output register takes a new result once the old one has gone
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = mpqa_pkg::OUT_TDATA_W'({res.occupancy, res.out_value});
            m_tuser_next  = res.status;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// stream testbench for min_priority_queue_array_top: queued requests, own queue predictor
// depends on mpqa_pkg and the rtl top level, checks every result in arrival order
module tb_top;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 2 * mpqa_pkg::CAPACITY + 8;
    localparam int RANDOM_ITEMS   = 1550;

    typedef enum int {
        PACE_FREE,
        PACE_SLOW_SRC,
        PACE_SLOW_SINK,
        PACE_BOTH
    } pace_t;

    typedef struct {
        mpqa_pkg::opcode_t                 op;
        logic signed [mpqa_pkg::VAL_W-1:0] value;
        pace_t                             pace;
    } pq_request_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [mpqa_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                             s_tuser  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [mpqa_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [mpqa_pkg::STAT_W-1:0]      m_tuser;

    pq_request_t     pending_requests[$];
    mpqa_pkg::res_t  expected_results[$];
    pace_t           cur_pace = PACE_FREE;
    int              error_count = 0;
    int              quiet_cycles = 0;

    // predictor copy of the queue contents, arrival order kept
    logic signed [mpqa_pkg::VAL_W-1:0] held_values[mpqa_pkg::CAPACITY];
    int                                held_count = 0;

    min_priority_queue_array_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic mpqa_pkg::res_t apply_request(mpqa_pkg::opcode_t op,
                                                     logic signed [mpqa_pkg::VAL_W-1:0] value);
        mpqa_pkg::res_t r;
        int             pick;
        r.out_value = '0;
        if (op == mpqa_pkg::OP_ENQUEUE) begin
            if (held_count >= mpqa_pkg::CAPACITY) begin
                r.status = mpqa_pkg::STAT_FULL;
            end else begin
                held_values[held_count] = value;
                held_count++;
                r.status = mpqa_pkg::STAT_ENQUEUED;
            end
        end else if (held_count == 0) begin
            r.status = mpqa_pkg::STAT_EMPTY;
        end else begin
            // strict less-than keeps the earliest of equal minima
            pick = 0;
            for (int i = 1; i < held_count; i++)
                if (held_values[i] < held_values[pick])
                    pick = i;
            r.out_value = held_values[pick];
            for (int i = pick; i + 1 < held_count; i++)
                held_values[i] = held_values[i + 1];
            held_count--;
            r.status = mpqa_pkg::STAT_DEQUEUED;
        end
        r.occupancy = held_count[mpqa_pkg::OCC_W-1:0];
        return r;
    endfunction

    function automatic int gap_pct(pace_t p);
        case (p)
            PACE_SLOW_SRC: return 74;
            PACE_BOTH:     return 13;
            default:       return 0;
        endcase
    endfunction

    function automatic int stall_pct(pace_t p);
        case (p)
            PACE_SLOW_SINK: return 74;
            PACE_BOTH:      return 13;
            default:        return 0;
        endcase
    endfunction

    // biased towards small values so that equal minima turn up often
    function automatic logic signed [mpqa_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0, 1, 2: return $urandom_range(6) - 3;
            3:       return 32'sh8000_0000 + $urandom_range(2);
            4:       return 32'sh7fff_ffff - $urandom_range(2);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(mpqa_pkg::opcode_t op, logic signed [mpqa_pkg::VAL_W-1:0] value,
                               pace_t pace);
        pq_request_t itm;
        itm.op    = op;
        itm.value = value;
        itm.pace  = pace;
        pending_requests.push_back(itm);
    endtask

    // driver: presents queued requests, predicts each one as it is accepted
    always @(posedge aclk) begin
        pq_request_t itm;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(mpqa_pkg::opcode_t'(s_tuser),
                                                         s_tdata[mpqa_pkg::VAL_W-1:0]));
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 &&
                        $urandom_range(99) >= gap_pct(pending_requests[0].pace)) begin
                    itm = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= itm.value;
                    s_tuser  <= itm.op;
                    cur_pace <= itm.pace;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: compares each result with the oldest expectation
    always @(posedge aclk) begin
        mpqa_pkg::res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d out_value %0d occupancy %0d",
                           m_tuser, $signed(m_tdata[mpqa_pkg::VAL_W-1:0]),
                           m_tdata[mpqa_pkg::VAL_W +: mpqa_pkg::OCC_W]);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        error_count++;
                    end
                    if (m_tdata[mpqa_pkg::VAL_W-1:0] !== want.out_value) begin
                        $error("out_value: expected %0d, got %0d", want.out_value,
                               $signed(m_tdata[mpqa_pkg::VAL_W-1:0]));
                        error_count++;
                    end
                    if (m_tdata[mpqa_pkg::VAL_W +: mpqa_pkg::OCC_W] !== want.occupancy) begin
                        $error("occupancy: expected %0d, got %0d", want.occupancy,
                               m_tdata[mpqa_pkg::VAL_W +: mpqa_pkg::OCC_W]);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct(cur_pace));
        end
    end

    // watchdog on cycles with no request and no result moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int    made;
        int    burst_len;
        int    enq_pct;
        pace_t pace;

        // directed: empty dequeue, extremes and ties, fill to full, overflow
        add_request(mpqa_pkg::OP_DEQUEUE, 32'sh7fff_ffff, PACE_FREE);
        add_request(mpqa_pkg::OP_ENQUEUE, 32'sh7fff_ffff, PACE_FREE);
        add_request(mpqa_pkg::OP_ENQUEUE, 32'sh8000_0000, PACE_FREE);
        add_request(mpqa_pkg::OP_ENQUEUE, 0, PACE_FREE);
        add_request(mpqa_pkg::OP_ENQUEUE, -1, PACE_FREE);
        add_request(mpqa_pkg::OP_ENQUEUE, 32'sh8000_0000, PACE_FREE);
        add_request(mpqa_pkg::OP_ENQUEUE, 1, PACE_FREE);
        add_request(mpqa_pkg::OP_ENQUEUE, 32'sh7fff_ffff, PACE_FREE);
        for (int i = 0; i < 9; i++)
            add_request(mpqa_pkg::OP_ENQUEUE, (i % 3) - 1, PACE_FREE);
        add_request(mpqa_pkg::OP_ENQUEUE, 32'sh5555_aaaa, PACE_FREE);
        add_request(mpqa_pkg::OP_DEQUEUE, 32'shffff_ffff, PACE_FREE);
        add_request(mpqa_pkg::OP_DEQUEUE, 0, PACE_FREE);
        add_request(mpqa_pkg::OP_DEQUEUE, $urandom, PACE_FREE);
        add_request(mpqa_pkg::OP_ENQUEUE, 32'sh8000_0000, PACE_FREE);
        add_request(mpqa_pkg::OP_DEQUEUE, 32'sh8000_0000, PACE_FREE);

        // random bursts leaning towards filling, draining or neither
        made = 0;
        while (made < RANDOM_ITEMS) begin
            pace      = pace_t'((made / 130) % 4);
            burst_len = $urandom_range(40, 8);
            case ($urandom_range(2))
                0:       enq_pct = 85;
                1:       enq_pct = 15;
                default: enq_pct = 50;
            endcase
            for (int i = 0; i < burst_len; i++) begin
                if ($urandom_range(99) < enq_pct)
                    add_request(mpqa_pkg::OP_ENQUEUE, pick_value(), pace);
                else
                    add_request(mpqa_pkg::OP_DEQUEUE, $urandom, pace);
            end
            made += burst_len;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // sampled away from the active edge so driver and monitor updates have settled
        @(negedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mpqa_pkg.sv
rtl/mpqa_core.sv
rtl/min_priority_queue_array_top.sv
test/tb_top.sv
